// File: rtl/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counting semaphore table package
// Shared beat types, operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Requested operation.
  typedef enum logic [1:0] {
    ACT_OPEN  = 2'd0,
    ACT_WAIT  = 2'd1,
    ACT_POST  = 2'd2,
    ACT_CLOSE = 2'd3
  } action_t;

  // Result status.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BLOCKED  = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOT_OPEN = 2'd3
  } status_t;

  // One request beat.
  typedef struct packed {
    action_t     action;
    logic [3:0]  sem_id;
    logic [5:0]  thread_id;
    logic [15:0] initial_count;
  } cst_in_t;

  // One result beat.
  typedef struct packed {
    status_t    status;
    logic [3:0] slot_out;
    logic       woke_valid;
    logic [5:0] woken_thread;
  } cst_out_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_WB
  } cst_state_t;

endpackage : cst_pkg
`default_nettype wire

// File: rtl/counting_semaphore_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counting semaphore table
// Table of counting semaphores with FIFO wait queues linked per thread.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (open, wait, post or close) is taken on a rising edge
//   where start is high and busy is low. busy stays high while the request
//   is in flight. The result beat is driven on out_rsp for one cycle,
//   flagged by out_valid, and is registered as the write-back state ends.
//   The receiver cannot stall; the result is simply presented once.
//   A new request is not taken while one is in flight: the slot entry is
//   read from the slot RAM at acceptance, the head waiter's link is read
//   from the link RAM in the link state, and both are computed and written
//   back in the write-back state. The result cycle overlaps the acceptance
//   of the next request.
//   Reset (synchronous, active low) frees every slot and returns to idle.
//   The RAMs are not cleared; a slot entry is only trusted after an open
//   wrote it, and the link entries only while the queue length covers them.
// ----------------------------------------------------------------------------
module counting_semaphore_table
  import cst_pkg::*;
#(
  parameter int SEM_SLOTS  = 16,
  parameter int THREADS    = 64,
  parameter int COUNT_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire cst_in_t  in_req,
  output logic          out_valid,
  output cst_out_t      out_rsp
);

  localparam int SLOT_W = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
  localparam int TID_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int LEN_W  = $clog2(THREADS + 1);

  // Per-slot entry kept in the slot RAM.
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [TID_W-1:0]      head;
    logic [TID_W-1:0]      tail;
    logic [LEN_W-1:0]      len;
  } slot_ent_t;

  // Reduce a 6-bit thread id modulo THREADS by restoring subtraction.
  function automatic logic [TID_W-1:0] tid_mod(input logic [5:0] v);
    int r;
    r = int'(v);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (THREADS << k)) begin
        r = r - (THREADS << k);
      end
    end
    return TID_W'(r);
  endfunction

  cst_state_t state_r, state_nxt;

  logic                  accept;
  logic                  link_re;
  logic                  wb;

  cst_in_t               req_r;
  logic [TID_W-1:0]      tid_r;
  logic [SEM_SLOTS-1:0]  slot_used_r, slot_used_nxt;
  logic                  free_found_r, free_found;
  logic [SLOT_W-1:0]     free_idx_r, free_idx;

  slot_ent_t             slot_mem [SEM_SLOTS];
  slot_ent_t             slot_rd_r;
  logic                  slot_we;
  logic [SLOT_W-1:0]     slot_waddr;
  slot_ent_t             slot_wdata;

  logic [TID_W-1:0]      link_mem [THREADS];
  logic [TID_W-1:0]      link_rd_r;
  logic                  link_we;

  logic [SLOT_W-1:0]     sid_idx;
  logic                  sid_ok;
  cst_out_t              rsp_nxt;
  cst_out_t              out_rsp_r;
  logic                  out_valid_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy    = 1'b1;
    link_re = 1'b0;
    wb      = 1'b0;
    case (state_r)
      ST_IDLE: busy    = 1'b0;
      ST_LINK: link_re = 1'b1;
      ST_WB:   wb      = 1'b1;
      default: busy    = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
      tid_r <= tid_mod(in_req.thread_id);
    end
  end

  // Slot RAM: read at acceptance, written back in the last cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_rd_r <= slot_mem[SLOT_W'(in_req.sem_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
  end

  // Link RAM: the head waiter's successor is read once the slot entry is in.
  always_ff @(posedge clk) begin
    if (link_re) begin
      link_rd_r <= link_mem[slot_rd_r.head];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[slot_rd_r.tail] <= tid_r;
    end
  end

  // Lowest free slot, registered during the link read cycle.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_re) begin
      free_found_r <= free_found;
      free_idx_r   <= free_idx;
    end
  end

  assign sid_idx = SLOT_W'(req_r.sem_id);
  assign sid_ok  = (int'(req_r.sem_id) < SEM_SLOTS) && slot_used_r[sid_idx];

  // Read-modify-write of the slot entry and the result.
  always_comb begin
    slot_used_nxt = slot_used_r;
    slot_we       = 1'b0;
    slot_waddr    = sid_idx;
    slot_wdata    = slot_rd_r;
    link_we       = 1'b0;
    rsp_nxt       = '0;
    rsp_nxt.status = STAT_OK;
    if (wb) begin
      if (req_r.action == ACT_OPEN) begin
        if (free_found_r) begin
          slot_used_nxt[free_idx_r] = 1'b1;
          slot_we          = 1'b1;
          slot_waddr       = free_idx_r;
          slot_wdata.count = COUNT_BITS'(req_r.initial_count);
          slot_wdata.len   = '0;
          rsp_nxt.slot_out = 4'(free_idx_r);
        end else begin
          rsp_nxt.status = STAT_FULL;
        end
      end else if (!sid_ok) begin
        rsp_nxt.status = STAT_NOT_OPEN;
      end else begin
        case (req_r.action)
          ACT_WAIT: begin
            if (slot_rd_r.count != '0) begin
              slot_we          = 1'b1;
              slot_wdata.count = slot_rd_r.count - COUNT_BITS'(1);
            end else begin
              rsp_nxt.status = STAT_BLOCKED;
              if (slot_rd_r.len < LEN_W'(THREADS)) begin
                slot_we = 1'b1;
                if (slot_rd_r.len == '0) begin
                  slot_wdata.head = tid_r;
                end else begin
                  link_we = 1'b1;
                end
                slot_wdata.tail = tid_r;
                slot_wdata.len  = slot_rd_r.len + LEN_W'(1);
              end
            end
          end
          ACT_POST: begin
            slot_we = 1'b1;
            if (slot_rd_r.len == '0) begin
              if (!(&slot_rd_r.count)) begin
                slot_wdata.count = slot_rd_r.count + COUNT_BITS'(1);
              end
            end else begin
              rsp_nxt.woke_valid   = 1'b1;
              rsp_nxt.woken_thread = 6'(slot_rd_r.head);
              slot_wdata.len       = slot_rd_r.len - LEN_W'(1);
              if (slot_rd_r.len != LEN_W'(1)) begin
                slot_wdata.head = link_rd_r;
              end
            end
          end
          ACT_CLOSE: begin
            slot_used_nxt[sid_idx] = 1'b0;
          end
          default: begin
            rsp_nxt.status = STAT_OK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_used_r <= slot_used_nxt;
      out_valid_r <= wb;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (wb) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule : counting_semaphore_table
`default_nettype wire

// File: rtl/cst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counting semaphore table port checker
// Watches the top-level ports for request and result timing and result codes.
// ----------------------------------------------------------------------------
module cst_checker
  import cst_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire cst_in_t  in_req,
  input wire logic     out_valid,
  input wire cst_out_t out_rsp
);

  logic req_beat;

  assign req_beat = start && !busy && (in_req.action == in_req.action);

  // A request beat is always answered by a result beat.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    req_beat |-> ##3 out_valid)
    else $error("result beat missing three cycles after a request beat");

  // A result beat only follows a busy period that has just ended.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result beat without a preceding busy period");

  // A wakeup is only reported by a successful post.
  a_woke_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.woke_valid |-> out_rsp.status == STAT_OK)
    else $error("wakeup reported with a failing status");

  // Failing or blocked results carry no slot and no woken thread.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != STAT_OK |->
      out_rsp.slot_out == 4'd0 && out_rsp.woken_thread == 6'd0)
    else $error("non-ok result carries slot or thread data");

endmodule : cst_checker

bind counting_semaphore_table cst_checker u_cst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
`default_nettype wire
